@@ sv/lrg_pkg.sv @@
// Shared types, constants and helpers for the line ramp generator.
`default_nettype none
package lrg_pkg;

  localparam int LvlW     = 48;
  localparam int FracBits = 16;
  localparam int MaxPairs = 128;
  localparam int PtrW     = $clog2(MaxPairs);
  localparam int CntW     = PtrW + 1;
  localparam int DvdW     = 49;
  localparam int DvsW     = 32;
  localparam int TtsW     = 34;

  localparam logic [LvlW-1:0] OneQ   = LvlW'(1) << FracBits;
  localparam logic [LvlW-1:0] MaxLvl = {1'b0, {(LvlW-1){1'b1}}};
  localparam logic [LvlW-1:0] MinLvl = {1'b1, {(LvlW-1){1'b0}}};
  localparam logic [TtsW-1:0] OneMs  = TtsW'(1) << 16;

  // Input command codes.
  localparam logic [2:0] FnTarget  = 3'd0;
  localparam logic [2:0] FnTick    = 3'd1;
  localparam logic [2:0] FnAppend  = 3'd2;
  localparam logic [2:0] FnRestart = 3'd3;
  localparam logic [2:0] FnStop    = 3'd4;
  localparam logic [2:0] FnClear   = 3'd5;
  localparam logic [2:0] FnSet     = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] RegFloat = 2'd0;
  localparam logic [1:0] RegTime  = 2'd1;
  localparam logic [1:0] RegGran  = 2'd2;
  localparam logic [1:0] RegStart = 2'd3;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_LIST, ST_SEG_RD, ST_SEG, ST_PLAN, ST_MUL, ST_CHECK,
    ST_DIV_IV, ST_GRAIN, ST_DIV_N, ST_DIV_S, ST_PLAN_END, ST_TICK, ST_FINISH,
    ST_OUT0, ST_OUT1
  } state_e;

  // Truncate a fixed point level toward zero.
  function automatic logic [LvlW-1:0] trunc_int(input logic [LvlW-1:0] v);
    logic [LvlW-1:0] fl;
    fl = {v[LvlW-1:FracBits], {FracBits{1'b0}}};
    if (v[LvlW-1] && (v[FracBits-1:0] != '0)) begin
      return fl + OneQ;
    end
    return fl;
  endfunction

  // Saturate a sum that grew by one bit back to the level width.
  function automatic logic [LvlW-1:0] sat_lvl(input logic [LvlW:0] s);
    if (s[LvlW] != s[LvlW-1]) begin
      return s[LvlW] ? MinLvl : MaxLvl;
    end
    return s[LvlW-1:0];
  endfunction

endpackage
`default_nettype wire

@@ sv/line_ramp_generator.sv @@
// Top level of the line ramp generator: command sequencer and ramp state.
//
//   Channel  Direction  Contents
//   s_axis   in         tuser: func; tdata: value, seg_time; tlast: last_pair
//   m_axis   out        tdata: level; tuser: ramp_done; tlast: last
//   cfg      in         cfg_index_i selects the register, cfg_data_i is the data
//
// An item is taken only in idle and the block stays busy until its results are
// delivered. A plan that uses the shared divider runs up to two divisions in series.
// Results wait in two output registers until taken. Reset is asynchronous and
// loads the register defaults; the pair list needs no clearing.
`default_nettype none
module line_ramp_generator
  import lrg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // value [47:0], seg_time [63:48]
  input  wire logic [2:0]  s_axis_tuser,   // func [2:0]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // level [47:0]
  output logic [0:0]       m_axis_tuser,   // ramp_done [0]
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  state_e state_q, state_d;

  logic            float_q;
  logic [15:0]     ramp_time_q, gran_q, at_q;
  logic [LvlW-1:0] cur_q, goal_q, origin_q, prev_q, size_q, pn_q;
  logic [16:0]     steps_q;
  logic [31:0]     ival_q;
  logic [TtsW-1:0] tts_q;
  logic            running_q, in_list_q, collecting_q;
  logic [CntW-1:0] count_q, ptr_q;
  logic [LvlW:0]   slope_q, diff_q;
  logic            neg_q;
  logic [47:0]     prod_q;
  logic [2:0]      func_q;
  logic [LvlW-1:0] val_q;
  logic [15:0]     st_q;
  logic            lp_q;
  logic [LvlW-1:0] r_lvl_q [2];
  logic            r_done_q [2];
  logic [1:0]      rcnt_q;

  // Divider and memory hookups.
  logic            div_start, div_done;
  logic [DvdW-1:0] div_dvd, div_quo;
  logic [DvsW-1:0] div_dvs;
  logic            mem_we;
  logic [LvlW+15:0] mem_rdata;

  // Helper values.
  logic            s_acc, cfg_acc;
  logic [CntW-1:0] eff_cnt, ptr_nx;
  logic [LvlW-1:0] pn_t, mem_tgt, step_sum;
  logic [LvlW:0]   slope_f, slope_i, abs_i;
  logic            plan_jump, int_equal, unit_ok;
  logic            tts_pos, list_end, list_lastseg;
  logic [LvlW-1:0] size_sat;
  logic [DvdW-1:0] quo_neg;

  assign s_acc   = s_axis_tvalid && s_axis_tready;
  assign cfg_acc = cfg_valid_i && cfg_ready_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    eff_cnt   = collecting_q ? count_q : '0;
    ptr_nx    = ptr_q + 1'b1;
    pn_t      = trunc_int(pn_q);
    mem_tgt   = mem_rdata[LvlW-1:0];
    slope_f   = {pn_q[LvlW-1], pn_q} - {cur_q[LvlW-1], cur_q};
    slope_i   = {pn_t[LvlW-1], pn_t} - {cur_q[LvlW-1], cur_q};
    abs_i     = slope_i[LvlW] ? -slope_i : slope_i;
    int_equal = !float_q && (pn_t == cur_q);
    plan_jump = float_q ? ((at_q == '0) || (cur_q == pn_q)) : (at_q == '0);
    unit_ok   = (diff_q[LvlW:32] == '0) && (prod_q < {16'b0, at_q, 16'b0});
    tts_pos   = !tts_q[TtsW-1] && (tts_q != '0);
    list_end  = ptr_nx >= count_q;
    list_lastseg = (ptr_nx + 1'b1) >= count_q;
    step_sum  = sat_lvl({cur_q[LvlW-1], cur_q} + {size_q[LvlW-1], size_q});
    quo_neg   = -div_quo;
    if (!neg_q) begin
      size_sat = (div_quo[DvdW-1:LvlW-1] != '0) ? MaxLvl : div_quo[LvlW-1:0];
    end else begin
      size_sat = (div_quo > {2'b01, {(LvlW-1){1'b0}}}) ? MinLvl : quo_neg[LvlW-1:0];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (s_acc) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        case (func_q)
          FnTarget:  state_d = ST_PLAN;
          FnTick:    state_d = running_q ? ST_TICK : ST_FINISH;
          FnAppend:  state_d = lp_q ? ST_LIST : ST_FINISH;
          FnRestart: state_d = (count_q != '0) ? ST_LIST : ST_PLAN;
          default:   state_d = ST_FINISH;
        endcase
      end
      ST_LIST:     state_d = ST_SEG_RD;
      ST_SEG_RD:   state_d = ST_SEG;
      ST_SEG:      state_d = ST_PLAN;
      ST_PLAN: begin
        if (int_equal || plan_jump) state_d = ST_FINISH;
        else if (float_q) state_d = ST_GRAIN;
        else state_d = ST_MUL;
      end
      ST_MUL:      state_d = ST_CHECK;
      ST_CHECK:    state_d = unit_ok ? ST_DIV_IV : ST_GRAIN;
      ST_DIV_IV:   if (div_done) state_d = ST_PLAN_END;
      ST_GRAIN:    state_d = (gran_q == '0) ? ST_PLAN_END : ST_DIV_N;
      ST_DIV_N: begin
        if (div_done) state_d = (div_quo[16:0] == '0) ? ST_PLAN_END : ST_DIV_S;
      end
      ST_DIV_S:    if (div_done) state_d = ST_PLAN_END;
      ST_PLAN_END: state_d = ST_FINISH;
      ST_TICK: begin
        if (tts_pos) state_d = ST_FINISH;
        else if (steps_q <= 17'd1 && in_list_q && !list_end) state_d = ST_SEG_RD;
        else state_d = ST_FINISH;
      end
      ST_FINISH:   state_d = (rcnt_q != '0) ? ST_OUT0 : ST_IDLE;
      ST_OUT0: begin
        if (m_axis_tready) state_d = (rcnt_q == 2'd2) ? ST_OUT1 : ST_IDLE;
      end
      ST_OUT1:     if (m_axis_tready) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Handshake, divider and memory controls.
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = (state_q == ST_OUT0) || (state_q == ST_OUT1);
    m_axis_tdata  = (state_q == ST_OUT1) ? r_lvl_q[1] : r_lvl_q[0];
    m_axis_tuser  = (state_q == ST_OUT1) ? r_done_q[1] : r_done_q[0];
    m_axis_tlast  = (state_q == ST_OUT1) || (rcnt_q == 2'd1);
    mem_we = (state_q == ST_DISPATCH) && (func_q == FnAppend) &&
             (eff_cnt < CntW'(MaxPairs));
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state_q)
      ST_CHECK: begin
        div_start = unit_ok;
        div_dvd   = {1'b0, at_q, 32'b0};
        div_dvs   = diff_q[31:0];
      end
      ST_GRAIN: begin
        div_start = (gran_q != '0);
        div_dvd   = DvdW'(at_q);
        div_dvs   = DvsW'(gran_q);
      end
      ST_DIV_N: begin
        div_start = div_done && (div_quo[16:0] != '0);
        div_dvd   = slope_q[LvlW] ? -slope_q : slope_q;
        div_dvs   = DvsW'(div_quo[16:0]);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  lrg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  lrg_pair_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (eff_cnt[PtrW-1:0]),
    .wdata_i ({st_q, val_q}),
    .raddr_i (ptr_q[PtrW-1:0]),
    .rdata_o (mem_rdata)
  );

  // Ramp state and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      float_q      <= 1'b0;
      ramp_time_q  <= 16'd1000;
      gran_q       <= 16'd20;
      at_q         <= 16'd1000;
      cur_q        <= '0;
      goal_q       <= '0;
      origin_q     <= '0;
      prev_q       <= OneQ;
      size_q       <= '0;
      steps_q      <= '0;
      ival_q       <= '0;
      tts_q        <= '0;
      running_q    <= 1'b0;
      in_list_q    <= 1'b0;
      collecting_q <= 1'b0;
      count_q      <= '0;
      ptr_q        <= '0;
      pn_q         <= '0;
      slope_q      <= '0;
      diff_q       <= '0;
      neg_q        <= 1'b0;
      prod_q       <= '0;
      func_q       <= '0;
      val_q        <= '0;
      st_q         <= '0;
      lp_q         <= 1'b0;
      r_lvl_q[0]   <= '0;
      r_lvl_q[1]   <= '0;
      r_done_q[0]  <= 1'b0;
      r_done_q[1]  <= 1'b0;
      rcnt_q       <= '0;
    end else begin
      state_q <= state_d;

      // Configuration writes must arrive only while idle; the block itself does not enforce this.
      if (cfg_acc) begin
        case (cfg_index_i)
          RegFloat: float_q <= cfg_data_i[0];
          RegTime: begin
            ramp_time_q <= cfg_data_i[15:0];
            at_q        <= cfg_data_i[15:0];
          end
          RegGran:  gran_q <= cfg_data_i[15:0];
          RegStart: begin
            cur_q    <= {cfg_data_i, 16'b0};
            origin_q <= {cfg_data_i, 16'b0};
          end
          default: ;
        endcase
      end

      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            func_q <= s_axis_tuser;
            val_q  <= s_axis_tdata[47:0];
            st_q   <= s_axis_tdata[63:48];
            lp_q   <= s_axis_tlast;
            rcnt_q <= '0;
          end
        end
        ST_DISPATCH: begin
          case (func_q)
            FnTarget: begin
              prev_q       <= val_q;
              at_q         <= ramp_time_q;
              count_q      <= '0;
              collecting_q <= 1'b0;
              in_list_q    <= 1'b0;
              pn_q         <= val_q;
            end
            FnTick: begin
              if (running_q) tts_q <= tts_q - OneMs;
            end
            FnAppend: begin
              count_q      <= mem_we ? eff_cnt + 1'b1 : eff_cnt;
              collecting_q <= !lp_q;
            end
            FnRestart: begin
              running_q <= 1'b0;
              if (count_q == '0) begin
                cur_q       <= origin_q;
                r_lvl_q[0]  <= float_q ? origin_q : trunc_int(origin_q);
                r_done_q[0] <= 1'b0;
                rcnt_q      <= 2'd1;
                pn_q        <= prev_q;
              end
            end
            FnStop: running_q <= 1'b0;
            FnClear: begin
              count_q      <= '0;
              collecting_q <= 1'b0;
              in_list_q    <= 1'b0;
            end
            FnSet: begin
              cur_q    <= val_q;
              origin_q <= val_q;
            end
            default: ;
          endcase
        end
        ST_LIST: begin
          running_q <= 1'b0;
          in_list_q <= count_q > CntW'(1);
          ptr_q     <= '0;
        end
        ST_SEG: begin
          at_q <= mem_rdata[LvlW+15:LvlW];
          pn_q <= mem_tgt;
        end
        ST_PLAN: begin
          running_q <= 1'b0;
          if (!float_q) goal_q <= pn_t;
          if (int_equal) begin
            steps_q   <= 17'd1;
            tts_q     <= {2'b0, at_q, 16'b0};
            running_q <= 1'b1;
          end else if (plan_jump) begin
            cur_q     <= float_q ? pn_q : pn_t;
            in_list_q <= 1'b0;
            r_lvl_q[rcnt_q[0]]  <= float_q ? pn_q : pn_t;
            r_done_q[rcnt_q[0]] <= 1'b1;
            rcnt_q    <= rcnt_q + 1'b1;
          end else begin
            if (float_q) goal_q <= pn_q;
            origin_q <= cur_q;
            slope_q  <= float_q ? slope_f : slope_i;
            diff_q   <= abs_i;
            neg_q    <= float_q ? slope_f[LvlW] : slope_i[LvlW];
          end
        end
        ST_MUL:   prod_q <= diff_q[31:0] * gran_q;
        ST_DIV_IV: begin
          if (div_done) begin
            ival_q  <= (div_quo[DvdW-1:32] != '0) ? 32'hFFFF_FFFF : div_quo[31:0];
            size_q  <= neg_q ? -OneQ : OneQ;
            steps_q <= {1'b0, diff_q[31:16]};
          end
        end
        ST_GRAIN: begin
          ival_q <= {gran_q, 16'b0};
          if (gran_q == '0) begin
            steps_q <= '0;
            size_q  <= '0;
          end
        end
        ST_DIV_N: begin
          if (div_done) begin
            steps_q <= div_quo[16:0];
            if (div_quo[16:0] == '0) size_q <= '0;
          end
        end
        ST_DIV_S:    if (div_done) size_q <= size_sat;
        ST_PLAN_END: begin
          tts_q     <= {2'b0, ival_q};
          running_q <= 1'b1;
        end
        ST_TICK: begin
          if (!tts_pos) begin
            if (steps_q <= 17'd1) begin
              steps_q   <= '0;
              running_q <= 1'b0;
              cur_q     <= goal_q;
              r_lvl_q[rcnt_q[0]]  <= float_q ? goal_q : trunc_int(goal_q);
              r_done_q[rcnt_q[0]] <= !in_list_q;
              rcnt_q    <= rcnt_q + 1'b1;
              if (in_list_q) begin
                ptr_q <= ptr_nx;
                if (list_end || list_lastseg) in_list_q <= 1'b0;
              end
            end else begin
              steps_q <= steps_q - 1'b1;
              cur_q   <= step_sum;
              r_lvl_q[rcnt_q[0]]  <= float_q ? step_sum : trunc_int(step_sum);
              r_done_q[rcnt_q[0]] <= 1'b0;
              rcnt_q  <= rcnt_q + 1'b1;
              tts_q   <= tts_q + {2'b0, ival_q};
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/lrg_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module lrg_div
  import lrg_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [DvdW-1:0] dividend_i,
  input  wire logic [DvsW-1:0] divisor_i,
  output logic                 done_o,
  output logic      [DvdW-1:0] quotient_o
);

  localparam int CntBits = $clog2(DvdW);

  logic                busy_q, done_q;
  logic [CntBits-1:0]  cnt_q;
  logic [DvsW-1:0]     rem_q, dvs_q;
  logic [DvdW-1:0]     dvd_q;
  logic [DvsW:0]       rem_sh, rem_sub;
  logic                ge;

  // One trial subtraction per cycle.
  always_comb begin
    rem_sh  = {rem_q, dvd_q[DvdW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    ge      = rem_sh >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      dvd_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntBits'(DvdW - 1);
      rem_q  <= '0;
      dvs_q  <= divisor_i;
      dvd_q  <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DvsW-1:0] : rem_sh[DvsW-1:0];
      dvd_q <= {dvd_q[DvdW-2:0], ge};
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule
`default_nettype wire

@@ sv/lrg_pair_mem.sv @@
// Storage for the list of target and time pairs.
`default_nettype none
module lrg_pair_mem
  import lrg_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [PtrW-1:0]    waddr_i,
  input  wire logic [LvlW+15:0]   wdata_i,
  input  wire logic [PtrW-1:0]    raddr_i,
  output logic      [LvlW+15:0]   rdata_o
);

  logic [LvlW+15:0] mem_q [MaxPairs];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire
